@@ sv/cff_pkg.sv @@
// Shared types, constants and helper function of the connection flood filter.
package cff_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 512;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SCORE_W = 24;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned EXP_W   = 16;
    localparam int unsigned LIMIT_W = 12;
    localparam int unsigned CLIM_W  = 8;
    localparam int unsigned STEP_W  = 8;

    // Decay numerator is score * 20, divisor is age + 15 (age never exceeds 16 bits).
    localparam int unsigned NUM_W        = SCORE_W + 5;
    localparam int unsigned DEN_W        = EXP_W + 1;
    localparam int unsigned DECAY_NUM    = 20;
    localparam int unsigned DECAY_OFFSET = 15;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [EXP_W-1:0]   EXPIRY_RST      = EXP_W'(300);
    localparam logic [LIMIT_W-1:0] SCORE_LIMIT_RST = LIMIT_W'(100);
    localparam logic [CLIM_W-1:0]  COUNT_LIMIT_RST = CLIM_W'(7);
    localparam logic [STEP_W-1:0]  SCORE_STEP_RST  = STEP_W'(30);

    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_EXPIRY      = 2'd0;
    localparam logic [1:0] REG_SCORE_LIMIT = 2'd1;
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd2;
    localparam logic [1:0] REG_SCORE_STEP  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  stamp;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
    } cff_entry_t;

    typedef struct packed {
        logic [EXP_W-1:0]   expiry;
        logic [LIMIT_W-1:0] score_limit;
        logic [CLIM_W-1:0]  count_limit;
        logic [STEP_W-1:0]  score_step;
    } cff_cfg_t;

    function automatic logic is_blocked(input logic [SCORE_W-1:0] score,
                                        input logic [COUNT_W-1:0] count,
                                        input cff_cfg_t cfg);
        logic [SCORE_W-1:0] lim;
        lim = {{(SCORE_W-LIMIT_W-8){1'b0}}, cfg.score_limit, 8'h00};
        return (score > lim) && (count > cfg.count_limit);
    endfunction

endpackage

@@ sv/cff_table.sv @@
// Client table memory: one write port, one read port with registered read data.
module cff_table #(
    parameter int unsigned DEPTH = cff_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  cff_pkg::cff_entry_t      wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output cff_pkg::cff_entry_t      rdata
);
    import cff_pkg::*;

    cff_entry_t mem [DEPTH];
    cff_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/cff_div.sv @@
// Restoring divider for the score decay, one quotient bit per cycle.
module cff_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cff_pkg::NUM_W-1:0] num,
    input  logic [cff_pkg::DEN_W-1:0] den,
    output logic [cff_pkg::NUM_W-1:0] quo,
    output logic                      done
);
    import cff_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                if (fits) begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

@@ sv/cff_regs.sv @@
// Configuration registers behind the APB-style port.
module cff_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cff_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cff_pkg::cff_cfg_t           cfg
);
    import cff_pkg::*;

    cff_cfg_t cfg_reg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expiry      <= EXPIRY_RST;
            cfg_reg.score_limit <= SCORE_LIMIT_RST;
            cfg_reg.count_limit <= COUNT_LIMIT_RST;
            cfg_reg.score_step  <= SCORE_STEP_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_EXPIRY:      cfg_reg.expiry      <= pwdata[EXP_W-1:0];
                REG_SCORE_LIMIT: cfg_reg.score_limit <= pwdata[LIMIT_W-1:0];
                REG_COUNT_LIMIT: cfg_reg.count_limit <= pwdata[CLIM_W-1:0];
                REG_SCORE_STEP:  cfg_reg.score_step  <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_EXPIRY:      prdata = 32'(cfg_reg.expiry);
            REG_SCORE_LIMIT: prdata = 32'(cfg_reg.score_limit);
            REG_COUNT_LIMIT: prdata = 32'(cfg_reg.count_limit);
            REG_SCORE_STEP:  prdata = 32'(cfg_reg.score_step);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/connection_flood_filter.sv @@
// Connection flood filter top level: control sequencer around the client table.
// After reset the table is cleared one entry per cycle, during which no transfer is taken on the
// input. Each connection is then handled by one pass over the table, one entry per cycle through
// the single read port of the table memory; an unknown client scans every entry and then takes
// over a table entry. A known client ends the pass at its entry; if it is not blocked, its score
// decay goes through a one-bit-per-cycle divider before the update. One item is in the block at
// a time; a finished result waits in the output register while the next item is taken.
module connection_flood_filter #(
    parameter int unsigned TABLE_ENTRIES = cff_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // client_address[31:0], now_seconds[63:32]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // rejected, newly_blocked, evicted_blocked, zeros
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cff_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cff_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_REPL  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    cff_cfg_t cfg;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [TIME_W-1:0] in_now_reg;

    cff_entry_t        hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              hit_blk_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_stamp_reg;
    logic [IDX_W-1:0]  all_idx_reg;
    logic [TIME_W-1:0] all_stamp_reg;

    logic res_rej_reg, res_new_reg, res_evb_reg;
    logic m_valid_reg;
    logic [2:0] m_bits_reg;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    cff_entry_t        mem_wdata, rd_entry;

    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DEN_W-1:0]  div_den;

    logic              idx_last, live, expire, match, rd_blk;
    logic [TIME_W-1:0] age, post_stamp;
    logic              out_free;

    logic [NUM_W:0]       score_sum;
    logic [SCORE_W-1:0]   new_score;
    logic [COUNT_W-1:0]   new_count;
    logic                 blk_after;
    logic [IDX_W-1:0]     pick_idx;

    cff_regs u_regs (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    cff_table #(.DEPTH(TABLE_ENTRIES)) u_table (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .re(mem_re), .raddr(mem_raddr), .rdata(rd_entry)
    );

    cff_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num), .den(div_den),
        .quo(div_quo), .done(div_done)
    );

    assign idx_last   = idx_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign age        = in_now_reg - rd_entry.stamp;
    assign live       = rd_entry.stamp != '0;
    assign expire     = live && ((in_now_reg < rd_entry.stamp) ||
                                 (age > TIME_W'(cfg.expiry)));
    assign match      = live && !expire && (rd_entry.addr == in_addr_reg);
    assign rd_blk     = is_blocked(rd_entry.score, rd_entry.count, cfg);
    assign post_stamp = expire ? '0 : rd_entry.stamp;
    assign out_free   = !m_valid_reg || m_tready;

    // The age of a live entry fits in 16 bits since it never exceeds the expiry.
    assign div_num = NUM_W'(rd_entry.score) * NUM_W'(DECAY_NUM);
    assign div_den = DEN_W'(age[EXP_W-1:0]) + DEN_W'(DECAY_OFFSET);

    assign score_sum = (NUM_W+1)'(div_quo) + (NUM_W+1)'({cfg.score_step, 8'h00});
    assign new_score = hit_blk_reg ? hit_reg.score :
                       (score_sum > (NUM_W+1)'(SCORE_MAX)) ? SCORE_MAX :
                       score_sum[SCORE_W-1:0];
    assign new_count = (hit_reg.count == COUNT_MAX) ? COUNT_MAX :
                       hit_reg.count + COUNT_W'(1);
    assign blk_after = is_blocked(new_score, new_count, cfg);
    assign pick_idx  = found_reg ? best_idx_reg : all_idx_reg;

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    mem_re     = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (expire) begin
                    mem_we          = 1'b1;
                    mem_wdata       = rd_entry;
                    mem_wdata.stamp = '0;
                end
                if (match) begin
                    if (rd_blk) begin
                        state_next = ST_UPD;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else if (idx_last) begin
                    state_next = ST_REPL;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + IDX_W'(1);
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                mem_we          = 1'b1;
                mem_waddr       = hit_idx_reg;
                mem_wdata.addr  = hit_reg.addr;
                mem_wdata.stamp = blk_after ? hit_reg.stamp : in_now_reg;
                mem_wdata.score = new_score;
                mem_wdata.count = new_count;
                state_next      = ST_OUT;
            end
            ST_REPL: begin
                mem_we          = 1'b1;
                mem_waddr       = pick_idx;
                mem_wdata.addr  = in_addr_reg;
                mem_wdata.stamp = in_now_reg;
                mem_wdata.score = '0;
                mem_wdata.count = COUNT_W'(1);
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_addr_reg <= s_tdata[31:0];
                        in_now_reg  <= s_tdata[63:32];
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (match) begin
                        hit_reg     <= rd_entry;
                        hit_idx_reg <= idx_reg;
                        hit_blk_reg <= rd_blk;
                    end else begin
                        // Oldest unblocked and oldest overall; strict compare keeps the lowest index.
                        if (!rd_blk && (!found_reg || post_stamp < best_stamp_reg)) begin
                            found_reg      <= 1'b1;
                            best_idx_reg   <= idx_reg;
                            best_stamp_reg <= post_stamp;
                        end
                        if (idx_reg == '0 || post_stamp < all_stamp_reg) begin
                            all_idx_reg   <= idx_reg;
                            all_stamp_reg <= post_stamp;
                        end
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_UPD: begin
                    res_rej_reg <= blk_after;
                    res_new_reg <= blk_after && !hit_blk_reg;
                    res_evb_reg <= 1'b0;
                end
                ST_REPL: begin
                    res_rej_reg <= 1'b0;
                    res_new_reg <= 1'b0;
                    res_evb_reg <= !found_reg;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_bits_reg <= {res_evb_reg, res_new_reg, res_rej_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_bits_reg};

endmodule
